### design/beep_and_melody_sequencer_core_defines.svh
// ---------------------------------------------------------------------------
// Beep and melody sequencer assertion macros
// Shared property macros for the sequencer checks.
// ---------------------------------------------------------------------------
`ifndef BEEP_AND_MELODY_SEQUENCER_CORE_DEFINES_SVH
`define BEEP_AND_MELODY_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication under reset
`define BMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define BMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bms_pkg.sv
// ---------------------------------------------------------------------------
// Beep and melody sequencer package
// Types, codes and helpers shared by the sequencer modules.
// ---------------------------------------------------------------------------
package bms_pkg;

    localparam int MAX_NOTES = 16;
    localparam int SLOT_W    = $clog2(MAX_NOTES);
    localparam int POS_W     = $clog2(MAX_NOTES + 1);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_NOTE  = 2'd3;

    localparam logic [3:0] REG_BEEP_FREQ = 4'd0;
    localparam logic [3:0] REG_PWM_DUTY  = 4'd1;
    localparam logic [3:0] REG_GAP       = 4'd2;
    localparam logic [3:0] REG_MEL_LEN   = 4'd3;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 32;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic        alerting;
        logic [7:0]  beep_count;
        logic [15:0] beep_on_ms;
        logic [15:0] beep_off_ms;
        logic [3:0]  note_slot;
        logic [15:0] note_freq_hz;
        logic [15:0] note_length_ms;
    } item_t;

    typedef struct packed {
        logic [15:0]      beep_freq_hz;
        logic [7:0]       pwm_duty;
        logic [15:0]      repeat_gap_ms;
        logic [POS_W-1:0] melody_count;
    } cfg_t;

    typedef struct packed {
        logic        sounding;
        logic [15:0] drive_freq_hz;
        logic [7:0]  drive_duty;
    } drive_t;

    function automatic logic reached(input logic [31:0] now, input logic [31:0] deadline);
        logic [31:0] diff;
        diff = now - deadline;
        return !diff[31];
    endfunction

endpackage

### design/bms_cfg.sv
// ---------------------------------------------------------------------------
// Beep and melody sequencer configuration registers
// Register file written by index; melody length saturated to the table size.
// ---------------------------------------------------------------------------
module bms_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [3:0]          wr_index,
    input  logic [15:0]         wr_data,
    output bms_pkg::cfg_t       cfg
);
    import bms_pkg::*;

    logic [15:0]      beep_freq_reg;
    logic [7:0]       pwm_duty_reg;
    logic [15:0]      gap_reg;
    logic [4:0]       mel_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beep_freq_reg <= 16'd2000;
            pwm_duty_reg  <= 8'd128;
            gap_reg       <= 16'd1000;
            mel_len_reg   <= 5'd0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_BEEP_FREQ: beep_freq_reg <= wr_data;
                REG_PWM_DUTY:  pwm_duty_reg  <= wr_data[7:0];
                REG_GAP:       gap_reg       <= wr_data;
                REG_MEL_LEN:   mel_len_reg   <= wr_data[4:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        cfg.beep_freq_hz  = beep_freq_reg;
        cfg.pwm_duty      = pwm_duty_reg;
        cfg.repeat_gap_ms = gap_reg;
        if (32'(mel_len_reg) > MAX_NOTES)
            cfg.melody_count = POS_W'(MAX_NOTES);
        else
            cfg.melody_count = POS_W'(mel_len_reg);
    end

endmodule

### design/bms_seq.sv
// ---------------------------------------------------------------------------
// Beep and melody sequencer state
// Beep run, melody player and note table; one item per cycle while go is high.
// ---------------------------------------------------------------------------
module bms_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  bms_pkg::item_t      item,
    input  bms_pkg::cfg_t       cfg,
    output bms_pkg::drive_t     result
);
    import bms_pkg::*;

    logic                   run_active_reg, run_active_next;
    logic                   phase_on_reg,   phase_on_next;
    logic [7:0]             phases_reg,     phases_next;
    logic [31:0]            beep_dl_reg,    beep_dl_next;
    logic [15:0]            on_len_reg,     on_len_next;
    logic [15:0]            off_len_reg,    off_len_next;
    logic                   playing_reg,    playing_next;
    logic [POS_W-1:0]       pos_reg,        pos_next;
    logic [31:0]            note_dl_reg,    note_dl_next;
    logic [31:0]            gap_dl_reg,     gap_dl_next;
    logic [15:0]            tone_reg,       tone_next;
    logic [31:0]            note_table [MAX_NOTES];

    logic [POS_W-1:0]       pos_inc;
    logic [SLOT_W-1:0]      rd_addr;
    logic [31:0]            entry;
    logic [7:0]             phases_dec;

    assign pos_inc    = pos_reg + POS_W'(1);
    assign rd_addr    = playing_reg ? pos_inc[SLOT_W-1:0] : SLOT_W'(0);
    assign entry      = note_table[rd_addr];
    assign phases_dec = (phases_reg != 8'd0) ? phases_reg - 8'd1 : phases_reg;

    always_comb
    begin
        run_active_next = run_active_reg;
        phase_on_next   = phase_on_reg;
        phases_next     = phases_reg;
        beep_dl_next    = beep_dl_reg;
        on_len_next     = on_len_reg;
        off_len_next    = off_len_reg;
        playing_next    = playing_reg;
        pos_next        = pos_reg;
        note_dl_next    = note_dl_reg;
        gap_dl_next     = gap_dl_reg;
        tone_next       = tone_reg;

        unique case (item.cmd)
            CMD_TICK:
            begin
                if (run_active_reg)
                begin
                    if (reached(item.now_ms, beep_dl_reg))
                    begin
                        phases_next = phases_dec;
                        if (phases_dec == 8'd0)
                        begin
                            run_active_next = 1'b0;
                            tone_next       = 16'd0;
                        end
                        else
                        begin
                            phase_on_next = !phase_on_reg;
                            if (!phase_on_reg)
                            begin
                                tone_next    = cfg.beep_freq_hz;
                                beep_dl_next = item.now_ms + 32'(on_len_reg);
                            end
                            else
                            begin
                                tone_next    = 16'd0;
                                beep_dl_next = item.now_ms + 32'(off_len_reg);
                            end
                        end
                    end
                end
                else if (item.alerting)
                begin
                    if (playing_reg)
                    begin
                        if (reached(item.now_ms, note_dl_reg))
                        begin
                            pos_next = pos_inc;
                            if (pos_inc >= cfg.melody_count)
                            begin
                                playing_next = 1'b0;
                                tone_next    = 16'd0;
                                gap_dl_next  = item.now_ms + 32'(cfg.repeat_gap_ms);
                            end
                            else
                            begin
                                tone_next    = entry[15:0];
                                note_dl_next = item.now_ms + 32'(entry[31:16]);
                            end
                        end
                    end
                    else if (reached(item.now_ms, gap_dl_reg)
                             && cfg.melody_count != POS_W'(0))
                    begin
                        pos_next     = POS_W'(0);
                        playing_next = 1'b1;
                        tone_next    = entry[15:0];
                        note_dl_next = item.now_ms + 32'(entry[31:16]);
                    end
                end
                else
                begin
                    playing_next = 1'b0;
                    gap_dl_next  = 32'd0;
                    tone_next    = 16'd0;
                end
            end
            CMD_START:
            begin
                if (item.beep_count != 8'd0)
                begin
                    run_active_next = 1'b1;
                    phase_on_next   = 1'b1;
                    phases_next     = {item.beep_count[6:0], 1'b0};
                    beep_dl_next    = item.now_ms + 32'(item.beep_on_ms);
                    on_len_next     = item.beep_on_ms;
                    off_len_next    = item.beep_off_ms;
                    tone_next       = cfg.beep_freq_hz;
                end
            end
            CMD_STOP:
            begin
                run_active_next = 1'b0;
                playing_next    = 1'b0;
                gap_dl_next     = 32'd0;
                tone_next       = 16'd0;
            end
            CMD_NOTE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg <= 1'b0;
            phase_on_reg   <= 1'b0;
            phases_reg     <= 8'd0;
            beep_dl_reg    <= 32'd0;
            on_len_reg     <= 16'd0;
            off_len_reg    <= 16'd0;
            playing_reg    <= 1'b0;
            pos_reg        <= '0;
            note_dl_reg    <= 32'd0;
            gap_dl_reg     <= 32'd0;
            tone_reg       <= 16'd0;
        end
        else if (go)
        begin
            run_active_reg <= run_active_next;
            phase_on_reg   <= phase_on_next;
            phases_reg     <= phases_next;
            beep_dl_reg    <= beep_dl_next;
            on_len_reg     <= on_len_next;
            off_len_reg    <= off_len_next;
            playing_reg    <= playing_next;
            pos_reg        <= pos_next;
            note_dl_reg    <= note_dl_next;
            gap_dl_reg     <= gap_dl_next;
            tone_reg       <= tone_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && item.cmd == CMD_NOTE && 32'(item.note_slot) < MAX_NOTES)
            note_table[item.note_slot[SLOT_W-1:0]] <= {item.note_length_ms, item.note_freq_hz};
    end

    always_comb
    begin
        result.sounding      = (tone_next != 16'd0);
        result.drive_freq_hz = tone_next;
        result.drive_duty    = result.sounding ? cfg.pwm_duty : 8'd0;
    end

endmodule

### design/beep_and_melody_sequencer_core.sv
// ---------------------------------------------------------------------------
// Beep and melody sequencer core
// Buzzer tone sequencer: beep runs over an alert melody, one drive word out
// for every command word in.
//
//   channel   dir   handshake            payload
//   s_*       in    s_tvalid/s_tready    s_tdata, s_tuser = cmd
//   m_*       out   m_tvalid/m_tready    m_tdata
//   cfg_*     in    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word per cycle sustained while m_tready is high; input register to
// output register, with the state update registered along with the output.
// rst_n clears all control state at once; no clearing pass.
// A stalled output holds the result; one further word waits in the input
// register. cfg_ready is always high.
// ---------------------------------------------------------------------------
`include "beep_and_melody_sequencer_core_defines.svh"

module beep_and_melody_sequencer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // now_ms[31:0], alerting[32], beep_count[40:33], beep_on_ms[56:41],
    // beep_off_ms[72:57], note_slot[76:73], note_freq_hz[92:77],
    // note_length_ms[108:93], zero pad
    input  logic [bms_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd[1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // sounding[0], drive_freq_hz[16:1], drive_duty[24:17], zero pad
    output logic [bms_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [3:0]                      cfg_index,
    input  logic [15:0]                     cfg_data
);
    import bms_pkg::*;

    logic       in_valid_reg;
    item_t      item_reg;
    logic       out_valid_reg;
    drive_t     out_reg;
    logic       advance;
    logic       go;
    cfg_t       cfg;
    drive_t     result;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign go        = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;

    bms_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bms_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (go)
                in_valid_reg <= 1'b0;

            if (go)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.cmd            <= s_tuser;
            item_reg.now_ms         <= s_tdata[31:0];
            item_reg.alerting       <= s_tdata[32];
            item_reg.beep_count     <= s_tdata[40:33];
            item_reg.beep_on_ms     <= s_tdata[56:41];
            item_reg.beep_off_ms    <= s_tdata[72:57];
            item_reg.note_slot      <= s_tdata[76:73];
            item_reg.note_freq_hz   <= s_tdata[92:77];
            item_reg.note_length_ms <= s_tdata[108:93];
        end
        if (go)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.drive_duty, out_reg.drive_freq_hz, out_reg.sounding};

    `BMS_ASSERT_NOW(a_silent_zero, m_tvalid && !m_tdata[0], m_tdata[24:1] == 24'd0, "silent word carries drive")
    `BMS_ASSERT_NOW(a_sound_freq, m_tvalid && m_tdata[0], m_tdata[16:1] != 16'd0, "sounding with zero frequency")
    `BMS_ASSERT_NEXT(a_take_held, s_tvalid && s_tready, in_valid_reg, "accepted word not held")
    `BMS_ASSERT_NOW(a_ready_empty, !out_valid_reg, s_tready, "input blocked with empty output")

endmodule

### verif/beep_and_melody_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Beep and melody sequencer core testbench
// Sends command words on the input stream and checks every drive word against
// a cycle-free model of the sequencer held in a scoreboard. Directed words cover
// beep runs, the phase-count cut, stop, rests and timestamp wrap. Random words
// then run under several register settings, with random idling on both
// streams, one long output hold-off and one pause for a full drain.
// ---------------------------------------------------------------------------
module beep_and_melody_sequencer_core_tb;

    import bms_pkg::*;

    localparam int ITEMS_PER_PHASE = 190;
    localparam int PHASES          = 8;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 120;
    localparam int WATCHDOG_LIMIT  = 4000;

    class drive_scoreboard;
        bit [15:0] beep_freq;
        bit [7:0]  duty;
        bit [15:0] gap_ms;
        bit [4:0]  mel_len;

        bit        run_active;
        bit        phase_on;
        bit [7:0]  phases_left;
        bit [31:0] beep_due;
        bit [15:0] on_len;
        bit [15:0] off_len;
        bit        melody_playing;
        bit [4:0]  note_pos;
        bit [31:0] note_due;
        bit [31:0] gap_due;
        bit [31:0] notes [MAX_NOTES];
        bit [15:0] tone;

        drive_t expected_drives [$];
        int     errors;
        int     checked;
        int     cmd_seen [4];

        function new();
            beep_freq = 16'd2000;
            duty      = 8'd128;
            gap_ms    = 16'd1000;
            mel_len   = 5'd0;
        endfunction

        function void complain(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s", msg);
        endfunction

        function void apply_register(logic [3:0] idx, logic [15:0] val);
            case (idx)
                REG_BEEP_FREQ: beep_freq = val;
                REG_PWM_DUTY:  duty      = val[7:0];
                REG_GAP:       gap_ms    = val;
                REG_MEL_LEN:   mel_len   = val[4:0];
                default: ;
            endcase
        endfunction

        function bit time_reached(bit [31:0] stamp, bit [31:0] due);
            bit [31:0] diff;
            diff = stamp - due;
            return !diff[31];
        endfunction

        function bit [4:0] notes_in_use();
            return (mel_len > MAX_NOTES) ? 5'(MAX_NOTES) : mel_len;
        endfunction

        function void play_current(bit [31:0] stamp);
            bit [31:0] entry;
            entry    = notes[note_pos[3:0]];
            tone     = entry[15:0];
            note_due = stamp + entry[31:16];
        endfunction

        function void step_beep(bit [31:0] stamp);
            if (!time_reached(stamp, beep_due))
                return;
            if (phases_left != 0)
                phases_left--;
            if (phases_left == 0)
            begin
                run_active = 1'b0;
                tone       = '0;
                return;
            end
            phase_on = !phase_on;
            if (phase_on)
            begin
                tone     = beep_freq;
                beep_due = stamp + on_len;
            end
            else
            begin
                tone     = '0;
                beep_due = stamp + off_len;
            end
        endfunction

        function void step_melody(bit [31:0] stamp);
            if (melody_playing)
            begin
                if (!time_reached(stamp, note_due))
                    return;
                note_pos++;
                if (note_pos >= notes_in_use())
                begin
                    melody_playing = 1'b0;
                    tone           = '0;
                    gap_due        = stamp + gap_ms;
                    return;
                end
                play_current(stamp);
            end
            else if (time_reached(stamp, gap_due))
            begin
                if (notes_in_use() == 0)
                    return;
                note_pos       = '0;
                melody_playing = 1'b1;
                play_current(stamp);
            end
        endfunction

        function void note_command(item_t it);
            drive_t d;
            cmd_seen[it.cmd]++;
            case (it.cmd)
                CMD_TICK:
                begin
                    if (run_active)
                        step_beep(it.now_ms);
                    else if (it.alerting)
                        step_melody(it.now_ms);
                    else
                    begin
                        melody_playing = 1'b0;
                        gap_due        = '0;
                        tone           = '0;
                    end
                end
                CMD_START:
                begin
                    if (it.beep_count != 0)
                    begin
                        run_active  = 1'b1;
                        phase_on    = 1'b1;
                        phases_left = {it.beep_count[6:0], 1'b0};
                        beep_due    = it.now_ms + it.beep_on_ms;
                        on_len      = it.beep_on_ms;
                        off_len     = it.beep_off_ms;
                        tone        = beep_freq;
                    end
                end
                CMD_STOP:
                begin
                    run_active     = 1'b0;
                    melody_playing = 1'b0;
                    gap_due        = '0;
                    tone           = '0;
                end
                default:
                    notes[it.note_slot] = {it.note_length_ms, it.note_freq_hz};
            endcase
            d.sounding      = (tone != 0);
            d.drive_freq_hz = tone;
            d.drive_duty    = (tone != 0) ? duty : 8'd0;
            expected_drives.push_back(d);
        endfunction

        function void check_drive(logic [31:0] word);
            drive_t want;
            checked++;
            if (expected_drives.size() == 0)
            begin
                complain($sformatf("drive word %0d (%h) arrived with nothing pending",
                                   checked, word));
                return;
            end
            want = expected_drives.pop_front();
            if (word[0] !== want.sounding || word[16:1] !== want.drive_freq_hz ||
                word[24:17] !== want.drive_duty)
                complain($sformatf({"drive word %0d: expected sounding=%0d freq=%0d duty=%0d,",
                                    " got sounding=%0d freq=%0d duty=%0d"},
                                   checked, want.sounding, want.drive_freq_hz,
                                   want.drive_duty, word[0], word[16:1], word[24:17]));
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [3:0]            cfg_index = '0;
    logic [15:0]           cfg_data  = '0;

    drive_scoreboard sb;
    bit [31:0]       clock_ms;
    int              quiet;
    int              burst;
    int              hold_request;
    int              longest_hold;
    int              settings_loaded;

    beep_and_melody_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic item_t scrambled();
        logic [127:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom()};
        return raw[$bits(item_t)-1:0];
    endfunction

    function automatic item_t tick_at(bit [31:0] stamp, bit alert);
        item_t it;
        it          = scrambled();
        it.cmd      = CMD_TICK;
        it.now_ms   = stamp;
        it.alerting = alert;
        return it;
    endfunction

    function automatic item_t start_at(bit [31:0] stamp, bit [7:0] count,
                                       bit [15:0] on_ms, bit [15:0] off_ms);
        item_t it;
        it             = scrambled();
        it.cmd         = CMD_START;
        it.now_ms      = stamp;
        it.beep_count  = count;
        it.beep_on_ms  = on_ms;
        it.beep_off_ms = off_ms;
        return it;
    endfunction

    function automatic item_t stop_now();
        item_t it;
        it     = scrambled();
        it.cmd = CMD_STOP;
        return it;
    endfunction

    function automatic item_t note_at(bit [3:0] slot, bit [15:0] freq, bit [15:0] len);
        item_t it;
        it                = scrambled();
        it.cmd            = CMD_NOTE;
        it.note_slot      = slot;
        it.note_freq_hz   = freq;
        it.note_length_ms = len;
        return it;
    endfunction

    // mostly advancing ticks, the rest beep runs, stops and table rewrites
    function automatic item_t random_command();
        int        pick;
        int        roll;
        bit [7:0]  count;
        bit [15:0] on_ms;
        bit [15:0] off_ms;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 85)
                clock_ms += $urandom_range(0, 30);
            else if (roll < 97)
                clock_ms += $urandom_range(31, 400);
            else
                clock_ms = $urandom();
            return tick_at(clock_ms, $urandom_range(0, 9) != 0);
        end
        if (pick < 88)
        begin
            roll  = $urandom_range(0, 99);
            count = (roll < 80) ? 8'($urandom_range(1, 4)) :
                    (roll < 85) ? 8'd128 :
                    (roll < 90) ? 8'd255 :
                    (roll < 93) ? 8'd0 : 8'($urandom_range(0, 255));
            on_ms  = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(0, 60));
            off_ms = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(0, 60));
            return start_at(clock_ms, count, on_ms, off_ms);
        end
        if (pick < 91)
            return stop_now();
        return note_at(4'($urandom_range(0, 15)),
                       ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)),
                       ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, 80)));
    endfunction

    // entered and left at a falling edge
    task automatic push_command(item_t it);
        int gap;
        gap = (quiet != 0 || burst != 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {3'b0, it.note_length_ms, it.note_freq_hz, it.note_slot, it.beep_off_ms,
                     it.beep_on_ms, it.beep_count, it.alerting, it.now_ms};
        s_tuser  <= it.cmd;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.note_command(it);
        @(negedge clk);
    endtask

    // drop the input and hold until every pending drive word is back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_settings(bit [15:0] freq, bit [7:0] duty, bit [15:0] gap,
                                 bit [4:0] len);
        logic [3:0]  idx [4];
        logic [15:0] val [4];
        idx = '{REG_BEEP_FREQ, REG_PWM_DUTY, REG_GAP, REG_MEL_LEN};
        val = '{freq, 16'(duty), gap, 16'(len)};
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (cfg_ready !== 1'b1);
            sb.apply_register(idx[i], val[i]);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    task automatic run_directed();
        push_command(tick_at(32'd0, 1'b0));
        push_command(tick_at(32'd5, 1'b1));
        push_command(start_at(32'd10, 8'd0, 16'd100, 16'd100));
        push_command(note_at(4'd0, 16'd0, 16'd0));
        push_command(note_at(4'd15, 16'hFFFF, 16'hFFFF));
        push_command(start_at(32'd20, 8'd128, 16'd5, 16'd5));
        push_command(tick_at(32'd24, 1'b1));
        push_command(tick_at(32'd25, 1'b0));
        push_command(start_at(32'd30, 8'd1, 16'd0, 16'd0));
        push_command(tick_at(32'd30, 1'b1));
        push_command(tick_at(32'd30, 1'b1));
        push_command(start_at(32'd40, 8'd255, 16'hFFFF, 16'hFFFF));
        push_command(tick_at(32'd41, 1'b1));
        push_command(stop_now());
        push_command(start_at(32'hFFFF_FFF0, 8'd2, 16'd32, 16'd8));
        push_command(tick_at(32'hFFFF_FFFF, 1'b0));
        push_command(tick_at(32'h0000_0010, 1'b0));
        push_command(tick_at(32'h0000_0018, 1'b1));
        push_command(tick_at(32'h8000_0038, 1'b1));
        push_command(stop_now());
    endtask

    initial
    begin
        int               remaining;
        bit [15:0]        freq_set [PHASES];
        bit [7:0]         duty_set [PHASES];
        bit [15:0]        gap_set  [PHASES];
        bit [4:0]         len_set  [PHASES];
        sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        clock_ms = 32'd100;
        for (int i = 0; i < MAX_NOTES; i++)
            push_command(note_at(4'(i), (i % 5 == 3) ? 16'd0 : 16'($urandom_range(200, 4000)),
                                 16'($urandom_range(1, 60))));

        freq_set = '{16'd2000, 16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(1, 65535)),
                     16'd1500, 16'($urandom_range(1, 65535)), 16'd440};
        duty_set = '{8'd128, 8'd255, 8'd0, 8'd77, 8'($urandom_range(0, 255)),
                     8'd200, 8'($urandom_range(0, 255)), 8'd1};
        gap_set  = '{16'd1000, 16'd0, 16'hFFFF, 16'd50, 16'($urandom_range(0, 2000)),
                     16'd20, 16'($urandom_range(0, 2000)), 16'd300};
        len_set  = '{5'd4, 5'd16, 5'd31, 5'd17, 5'($urandom_range(0, 31)),
                     5'd1, 5'($urandom_range(0, 31)), 5'd0};

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            if (p == 5)
                clock_ms = 32'hFFFF_F000;
            load_settings(freq_set[p], duty_set[p], gap_set[p], len_set[p]);
            quiet = (p == 1 || p == 6);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == 2 && n == 60)
                begin
                    hold_request = HOLD_CYCLES;
                    burst        = 1;
                end
                if (p == 2 && n == 90)
                    burst = 0;
                if (p == 4 && n == 100)
                    settle();
                push_command(random_command());
            end
        end
        quiet = 0;
        settle();

        remaining = sb.pending();
        if (remaining != 0)
            sb.complain($sformatf("%0d expected drive words never arrived", remaining));
        $display("Covered %0d command words (%0d ticks, %0d beep starts, %0d stops, %0d note writes)",
                 sb.cmd_seen[CMD_TICK] + sb.cmd_seen[CMD_START] + sb.cmd_seen[CMD_STOP]
                 + sb.cmd_seen[CMD_NOTE], sb.cmd_seen[CMD_TICK], sb.cmd_seen[CMD_START],
                 sb.cmd_seen[CMD_STOP], sb.cmd_seen[CMD_NOTE]);
        $display("over %0d register settings; %0d drive words checked, %0d-cycle output hold-off, %0d errors",
                 settings_loaded, sb.checked, longest_hold, sb.errors);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                stall        = hold_request;
                longest_hold = hold_request;
                hold_request = 0;
            end
            else
                stall = (quiet != 0) ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            sb.check_drive(m_tdata);
            @(negedge clk);
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/bms_pkg.sv
design/bms_cfg.sv
design/bms_seq.sv
design/beep_and_melody_sequencer_core.sv
verif/beep_and_melody_sequencer_core_tb.sv
